// ----- hw/rtl/lvr_pkg.sv -----
`timescale 1ns / 1ps

package lvr_pkg;

    // Default fixed point format: FRAC_BITS fraction bits, SPEED_BITS integer bits.
    localparam int FRAC_BITS_DEF  = 16;
    localparam int SPEED_BITS_DEF = 25;

    // Field widths of the item and result channels.
    localparam int REQ_W    = 3;
    localparam int TARGET_W = 25;
    localparam int FACTOR_W = 16;
    localparam int SPEED_W  = 25;

    // The factor is Q3.12.
    localparam int Q_SHIFT = 12;

    // Configuration registers.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int ACCEL_W    = 24;
    localparam int PERIOD_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RATE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD_US = 2'd1;

    localparam logic [ACCEL_W-1:0]  ACCEL_RATE_RST       = 24'd1000;
    localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_US_RST = 16'd5000;

    // Largest integer speed magnitude on the result channel.
    localparam logic [SPEED_W-2:0] OUT_MAX = 24'hFFFFFF;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_START       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TICK        = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SPEED_OVR   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ACCEL_OVR   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STOP        = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]           req_type;
        logic signed [TARGET_W-1:0] target_speed;
        logic signed [FACTOR_W-1:0] factor;
    } t_item;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      at_target;
    } t_result;

endpackage

// ----- hw/rtl/linear_velocity_ramp_top.sv -----
`timescale 1ns / 1ps

// Linear velocity ramp for a stepper axis, in signed fixed point with FRAC_BITS
// fraction bits. Each transfer on the item channel (start, tick, speed override,
// acceleration override or stop) produces exactly one transfer on the result
// channel carrying the integer speed and an at-target flag. Items pass through
// an input register and a result register, so the block sustains one item per
// clock while the result channel is ready and no base step is being recomputed;
// the state update for one item is finished within the cycle it leaves the input
// register, so back-to-back ticks see each other's result. The base step per tick
// (accel_rate * update_period_us / 1e6) is recomputed after reset and after every
// configuration write. The division by 1e6 runs as 16-bit quotient digits, one
// per cycle, each found by a reciprocal multiplication; while the dividend is
// loaded and its digits are found, the item channel is not ready. Configuration
// writes are expected only while no item is in flight.
module linear_velocity_ramp_top import lvr_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int SPEED_BITS = SPEED_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port.
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_wdata,
    // Item channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [REQ_W-1:0]            i_req_type,
    input  logic signed [TARGET_W-1:0]  i_target_speed,
    input  logic signed [FACTOR_W-1:0]  i_factor,
    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SPEED_W-1:0]   o_speed,
    output logic                        o_at_target
);

    localparam int QW = SPEED_BITS + FRAC_BITS;

    logic [ACCEL_W-1:0]  r_accel_rate;
    logic [PERIOD_W-1:0] r_update_period_us;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;

    t_result       core_result;
    logic [QW-2:0] step_cfg;
    logic          step_busy;
    logic          advance;
    logic          in_xfer;

    // Configuration registers. A write to an index outside the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_rate       <= ACCEL_RATE_RST;
            r_update_period_us <= UPDATE_PERIOD_US_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ACCEL_RATE:       r_accel_rate       <= i_cfg_wdata[ACCEL_W-1:0];
                CFG_UPDATE_PERIOD_US: r_update_period_us <= i_cfg_wdata[PERIOD_W-1:0];
                default:              ;
            endcase
        end
    end

    // The base step is recomputed whenever the configuration changes.
    lvr_step_div #(
        .FRAC_BITS  (FRAC_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_step_div (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_restart          (i_cfg_wr_en),
        .i_accel_rate       (r_accel_rate),
        .i_update_period_us (r_update_period_us),
        .o_busy             (step_busy),
        .o_step             (step_cfg)
    );

    // An item leaves the input register when the result register is free or
    // is being emptied in the same cycle. That same cycle commits its state
    // update in the core.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !step_busy && (!r_in_valid || advance);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_item.req_type     <= i_req_type;
            r_item.target_speed <= i_target_speed;
            r_item.factor       <= i_factor;
        end
    end

    lvr_core #(
        .FRAC_BITS  (FRAC_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_item     (r_item),
        .i_step_cfg (step_cfg),
        .o_result   (core_result)
    );

    // Result register: holds one finished result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_speed     = r_out.speed;
    assign o_at_target = r_out.at_target;

    // A configuration write must hold off the item channel on the next cycle,
    // while the base step is being recomputed.
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> !o_in_ready)
        else $error("item channel ready while the base step is recomputed");

    // A result only appears after an item sat in the input register.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result register loaded without an item");

    // The integer speed is saturated symmetrically and never reaches the most
    // negative code.
    a_speed_symmetric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_speed != $signed({1'b1, {(SPEED_W-1){1'b0}}})))
        else $error("speed outside the saturated range");

endmodule

// ----- hw/rtl/lvr_mul_q12.sv -----
`timescale 1ns / 1ps

// Signed value times a Q3.12 factor, truncated toward zero and saturated.
module lvr_mul_q12 import lvr_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int SPEED_BITS = SPEED_BITS_DEF
) (
    input  logic signed [SPEED_BITS+FRAC_BITS-1:0] i_a,
    input  logic signed [FACTOR_W-1:0]             i_f,
    output logic signed [SPEED_BITS+FRAC_BITS-1:0] o_p
);

    localparam int QW = SPEED_BITS + FRAC_BITS;
    localparam int PW = QW - 1 + FACTOR_W;
    localparam int MW = PW - Q_SHIFT;
    localparam logic [QW-2:0] SMAX_MAG = {{(SPEED_BITS-1){1'b1}}, {FRAC_BITS{1'b0}}};

    logic [QW-1:0]       a_abs;
    logic [FACTOR_W-1:0] f_abs;
    logic [PW-1:0]       prod;
    logic [MW-1:0]       m;
    logic [QW-2:0]       mag;
    logic                neg;

    always_comb begin
        a_abs = i_a[QW-1] ? QW'(-i_a) : QW'(i_a);
        f_abs = i_f[FACTOR_W-1] ? FACTOR_W'(-i_f) : FACTOR_W'(i_f);
        prod  = PW'(a_abs[QW-2:0]) * PW'(f_abs);
        m     = prod[PW-1:Q_SHIFT];
        mag   = (m > MW'(SMAX_MAG)) ? SMAX_MAG : m[QW-2:0];
        neg   = i_a[QW-1] ^ i_f[FACTOR_W-1];
        o_p   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

endmodule

// ----- hw/rtl/lvr_step_div.sv -----
`timescale 1ns / 1ps

// Base step per tick: accel_rate * update_period_us * 2^FRAC_BITS / 1e6.
// Since 1e6 = 64 * 15625, the dividend is the product shifted by FRAC_BITS - 6,
// divided by 15625 in 16-bit digits, most significant digit first. Each digit
// quotient comes from a multiplication by the reciprocal of 15625, which is exact
// for any partial dividend below 2^30. After a restart the step is ready once the
// dividend has been loaded and every digit has been found.
module lvr_step_div import lvr_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int SPEED_BITS = SPEED_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_restart,
    input  logic [ACCEL_W-1:0]                  i_accel_rate,
    input  logic [PERIOD_W-1:0]                 i_update_period_us,
    output logic                                o_busy,
    output logic [SPEED_BITS+FRAC_BITS-2:0]     o_step
);

    localparam int QW      = SPEED_BITS + FRAC_BITS;
    localparam int PROD_W  = ACCEL_W + PERIOD_W;
    localparam int POW2_SH = 6;
    localparam int DVD_W   = PROD_W + FRAC_BITS - POW2_SH;
    localparam int DIG_W   = 16;
    localparam int NDIG    = (DVD_W + DIG_W - 1) / DIG_W;
    localparam int EXT_W   = NDIG * DIG_W;
    localparam int CNT_W   = $clog2(NDIG + 1);
    localparam int REM_W   = 14;
    localparam int PART_W  = REM_W + DIG_W;
    localparam int RCP_W   = PART_W + 1;
    localparam int RCP_SH  = PART_W + REM_W;
    localparam int RPROD_W = PART_W + RCP_W;
    localparam logic [REM_W-1:0] DIVISOR = 14'd15625;
    // Reciprocal of the divisor, ceil(2^44 / 15625).
    localparam logic [RCP_W-1:0] RECIP = 31'd1125899907;
    localparam logic [QW-2:0]  SMAX_MAG = {{(SPEED_BITS-1){1'b1}}, {FRAC_BITS{1'b0}}};

    logic               r_load, n_load;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [EXT_W-1:0]   r_dvd, n_dvd;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [PROD_W-1:0]  prod;
    logic [DVD_W-1:0]   dvd_init;
    logic [PART_W-1:0]  part;
    logic [RPROD_W-1:0] rprod;
    logic [DIG_W-1:0]   qdig;
    logic [PART_W-1:0]  qmul;

    always_comb begin
        prod     = PROD_W'(i_accel_rate) * PROD_W'(i_update_period_us);
        dvd_init = {prod, {(FRAC_BITS-POW2_SH){1'b0}}};
        // The running remainder is below 15625, so the partial dividend stays
        // below 15625 * 2^16 and its quotient fits one digit.
        part     = {r_rem, r_dvd[EXT_W-1 -: DIG_W]};
        rprod    = RPROD_W'(part) * RPROD_W'(RECIP);
        qdig     = rprod[RCP_SH +: DIG_W];
        qmul     = PART_W'(qdig) * PART_W'(DIVISOR);
        n_load = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        if (i_restart) begin
            n_load = 1'b1;
            n_cnt  = '0;
        end else if (r_load) begin
            n_dvd = EXT_W'(dvd_init);
            n_rem = '0;
            n_cnt = CNT_W'(NDIG);
        end else if (r_cnt != '0) begin
            n_dvd = {r_dvd[EXT_W-DIG_W-1:0], qdig};
            n_rem = REM_W'(part - qmul);
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b1;
            r_cnt  <= '0;
        end else begin
            r_load <= n_load;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_busy = r_load | (r_cnt != '0);
    assign o_step = (r_dvd > EXT_W'(SMAX_MAG)) ? SMAX_MAG : r_dvd[QW-2:0];

endmodule

// ----- hw/rtl/lvr_core.sv -----
`timescale 1ns / 1ps

// Ramp state and the combinational update applied to one item, committed on i_fire.
module lvr_core import lvr_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int SPEED_BITS = SPEED_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  t_item                           i_item,
    input  logic [SPEED_BITS+FRAC_BITS-2:0] i_step_cfg,
    output t_result                         o_result
);

    localparam int QW = SPEED_BITS + FRAC_BITS;
    localparam int IW = SPEED_BITS - 1;
    localparam int TOL = ((1 << FRAC_BITS) + 999) / 1000;
    localparam logic signed [QW:0] TOL_Q = (QW+1)'(TOL);
    localparam logic [QW-2:0] SMAX_MAG = {{(SPEED_BITS-1){1'b1}}, {FRAC_BITS{1'b0}}};
    localparam logic signed [QW:0] SMAX_X = $signed({2'b00, SMAX_MAG});
    localparam logic signed [32:0] TGT_LIM = 33'((64'd1 << (SPEED_BITS - 1)) - 64'd1);

    function automatic logic f_near(input logic signed [QW-1:0] a,
                                    input logic signed [QW-1:0] b);
        logic signed [QW:0] d;
        d = $signed({a[QW-1], a}) - $signed({b[QW-1], b});
        return (d < TOL_Q) && (d > -TOL_Q);
    endfunction

    function automatic logic signed [SPEED_W-1:0] f_to_int(input logic signed [QW-1:0] q);
        logic [QW-1:0]      mag;
        logic [31:0]        iv;
        logic [SPEED_W-2:0] ic;
        mag = q[QW-1] ? QW'(-q) : QW'(q);
        iv  = 32'(mag[QW-2:FRAC_BITS]);
        ic  = (iv > 32'(OUT_MAX)) ? OUT_MAX : iv[SPEED_W-2:0];
        return q[QW-1] ? -$signed({1'b0, ic}) : $signed({1'b0, ic});
    endfunction

    logic signed [QW-1:0] r_speed_now, n_speed_now;
    logic signed [QW-1:0] r_speed_goal, n_speed_goal;
    logic signed [QW-1:0] r_goal_base_q, n_goal_base_q;
    logic [QW-2:0]        r_step_base, n_step_base;
    logic [QW-2:0]        r_step_scaled, n_step_scaled;
    logic signed [QW-1:0] r_step_signed, n_step_signed;

    logic is_start, is_tick, is_speed, is_accel, is_stop;
    logic signed [32:0]         tgt_x;
    logic signed [32:0]         tgt_c;
    logic signed [QW-1:0]       tgt_q;
    logic signed [QW-1:0]       mul_a_op;
    logic signed [FACTOR_W-1:0] mul_a_f;
    logic signed [QW-1:0]       prod_a;
    logic signed [QW-1:0]       prod_b;
    logic signed [QW-1:0]       now_ref;
    logic signed [QW-1:0]       scaled_s;
    logic signed [QW-1:0]       sign_step;
    logic signed [QW:0]         sum;
    logic signed [QW-1:0]       sum_sat;
    logic signed [QW-1:0]       moved;
    logic                       near_old;
    logic                       near_new;
    logic                       f_pos;

    always_comb begin
        is_start = 1'b0;
        is_tick  = 1'b0;
        is_speed = 1'b0;
        is_accel = 1'b0;
        is_stop  = 1'b0;
        case (i_item.req_type)
            REQ_START:     is_start = 1'b1;
            REQ_TICK:      is_tick  = 1'b1;
            REQ_SPEED_OVR: is_speed = 1'b1;
            REQ_ACCEL_OVR: is_accel = 1'b1;
            REQ_STOP:      is_stop  = 1'b1;
            default:       ;
        endcase
    end

    always_comb begin
        // Base target moved into the fixed point range, saturated.
        tgt_x = 33'($signed(i_item.target_speed));
        if (tgt_x > TGT_LIM) begin
            tgt_c = TGT_LIM;
        end else if (tgt_x < -TGT_LIM) begin
            tgt_c = -TGT_LIM;
        end else begin
            tgt_c = tgt_x;
        end
        tgt_q = $signed({tgt_c[SPEED_BITS-1:0], {FRAC_BITS{1'b0}}});

        // Stop is a speed override with a zero factor.
        if (is_accel) begin
            mul_a_op = $signed({1'b0, r_step_base});
        end else if (is_start) begin
            mul_a_op = tgt_q;
        end else begin
            mul_a_op = r_goal_base_q;
        end
        mul_a_f = is_stop ? '0 : $signed(i_item.factor);
    end

    lvr_mul_q12 #(
        .FRAC_BITS  (FRAC_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_mul_goal (
        .i_a (mul_a_op),
        .i_f (mul_a_f),
        .o_p (prod_a)
    );

    lvr_mul_q12 #(
        .FRAC_BITS  (FRAC_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_mul_step (
        .i_a (r_step_signed),
        .i_f ($signed(i_item.factor)),
        .o_p (prod_b)
    );

    always_comb begin
        now_ref   = is_start ? '0 : r_speed_now;
        scaled_s  = is_start ? $signed({1'b0, i_step_cfg}) : $signed({1'b0, r_step_scaled});
        sign_step = (prod_a > now_ref) ? scaled_s : -scaled_s;
        near_old  = f_near(r_speed_now, r_speed_goal);
        f_pos     = !i_item.factor[FACTOR_W-1] && (i_item.factor != '0);

        sum = $signed({r_speed_now[QW-1], r_speed_now})
            + $signed({r_step_signed[QW-1], r_step_signed});
        if (sum > SMAX_X) begin
            sum_sat = SMAX_X[QW-1:0];
        end else if (sum < -SMAX_X) begin
            sum_sat = QW'(-SMAX_X);
        end else begin
            sum_sat = sum[QW-1:0];
        end

        // Clamp at the goal in the direction of travel.
        if (!r_step_signed[QW-1] && (r_step_signed != '0)) begin
            moved = (sum_sat > r_speed_goal) ? r_speed_goal : sum_sat;
        end else begin
            moved = (sum_sat < r_speed_goal) ? r_speed_goal : sum_sat;
        end

        n_speed_now   = r_speed_now;
        n_speed_goal  = r_speed_goal;
        n_goal_base_q = r_goal_base_q;
        n_step_base   = r_step_base;
        n_step_scaled = r_step_scaled;
        n_step_signed = r_step_signed;
        if (is_start) begin
            n_goal_base_q = tgt_q;
            n_step_base   = i_step_cfg;
            n_step_scaled = i_step_cfg;
            n_speed_now   = '0;
            n_speed_goal  = prod_a;
            n_step_signed = sign_step;
        end else if (is_tick) begin
            if (!near_old) begin
                n_speed_now = moved;
            end
        end else if (is_speed || is_stop) begin
            n_speed_goal  = prod_a;
            n_step_signed = sign_step;
        end else if (is_accel && f_pos) begin
            n_step_scaled = prod_a[QW-2:0];
            n_step_signed = prod_b;
        end

        near_new = f_near(n_speed_now, n_speed_goal);
        o_result.at_target = is_tick ? near_old : near_new;
        if (is_start || is_stop) begin
            o_result.speed = '0;
        end else if (is_tick && near_old) begin
            o_result.speed = f_to_int(r_speed_goal);
        end else begin
            o_result.speed = f_to_int(n_speed_now);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_now   <= '0;
            r_speed_goal  <= '0;
            r_goal_base_q <= '0;
            r_step_base   <= '0;
            r_step_scaled <= '0;
            r_step_signed <= '0;
        end else if (i_fire) begin
            r_speed_now   <= n_speed_now;
            r_speed_goal  <= n_speed_goal;
            r_goal_base_q <= n_goal_base_q;
            r_step_base   <= n_step_base;
            r_step_scaled <= n_step_scaled;
            r_step_signed <= n_step_signed;
        end
    end

endmodule
